>>> hw/rtl/stpdir_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stpdir_pkg - shared constants and types
// Command codes, register indexes, arithmetic widths and the result layout
// for the step/direction generator.
// ----------------------------------------------------------------------------
package stpdir_pkg;

    // command codes carried in tuser
    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_MOVE    = 3'd1;
    localparam logic [2:0] CMD_HOME    = 3'd2;
    localparam logic [2:0] CMD_ENABLE  = 3'd3;
    localparam logic [2:0] CMD_DISABLE = 3'd4;
    localparam logic [2:0] CMD_CLEAR   = 3'd5;

    // configuration register indexes
    localparam logic [1:0] REG_SPM    = 2'd0;
    localparam logic [1:0] REG_SPEED  = 2'd1;
    localparam logic [1:0] REG_SETTLE = 2'd2;

    localparam logic [15:0] SPM_RESET    = 16'd80;
    localparam logic [15:0] SPEED_RESET  = 16'd2560;
    localparam logic [15:0] SETTLE_RESET = 16'd50;

    // 1e6 us scaled by the 8 fraction bits of the speed
    localparam logic [31:0] PERIOD_NUM = 32'd256000000;

    // serial arithmetic widths
    localparam int MUL_AW = 24;
    localparam int MUL_BW = 16;
    localparam int DIV_W  = 32;

    // result item, packed from the lowest bit up in reverse order of listing
    typedef struct packed {
        logic        pad;
        logic [15:0] missed_count;
        logic [31:0] position_steps;
        logic [31:0] steps_left;
        logic        moving;
        logic        driver_enabled;
        logic        direction;
        logic [2:0]  step_toggles;
        logic        step_level;
    } t_result;

endpackage
`default_nettype wire

>>> hw/rtl/stpdir_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stpdir_mul - bit-serial unsigned multiplier
// Shift-and-add, one multiplier bit per cycle; o_done pulses with the
// product valid.
// ----------------------------------------------------------------------------
module stpdir_mul #(
    parameter int AW = stpdir_pkg::MUL_AW,
    parameter int BW = stpdir_pkg::MUL_BW
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [AW-1:0]      i_a,
    input  wire logic [BW-1:0]      i_b,
    output logic                    o_done,
    output logic [AW+BW-1:0]        o_prod
);
    localparam int PW = AW + BW;
    localparam int CW = (BW > 1) ? $clog2(BW) : 1;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] r_acc;
    logic [PW-1:0] r_a;
    logic [BW-1:0] r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(BW - 1);
                r_acc  <= '0;
                r_a    <= PW'(i_a);
                r_b    <= i_b;
            end else if (r_busy) begin
                if (r_b[0]) begin
                    r_acc <= r_acc + r_a;
                end
                r_a <= r_a << 1;
                r_b <= r_b >> 1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CW'(1);
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule
`default_nettype wire

>>> hw/rtl/stpdir_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stpdir_div - bit-serial restoring divider
// One quotient bit per cycle, unsigned; divisor must be non-zero.
// ----------------------------------------------------------------------------
module stpdir_div #(
    parameter int W = stpdir_pkg::DIV_W
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_dividend,
    input  wire logic [W-1:0] i_divisor,
    output logic              o_done,
    output logic [W-1:0]      o_quot,
    output logic [W-1:0]      o_rem
);
    localparam int CW = $clog2(W);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_dvs;

    logic [W:0]    w_trial;
    logic [W-1:0]  w_shift;

    always_comb begin
        w_shift = {r_rem[W-2:0], r_quo[W-1]};
        w_trial = {r_rem, r_quo[W-1]} - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W - 1);
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                // no borrow: the divisor fits, take the difference
                if (!w_trial[W]) begin
                    r_rem <= w_trial[W-1:0];
                end else begin
                    r_rem <= w_shift;
                end
                r_quo <= {r_quo[W-2:0], ~w_trial[W]};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CW'(1);
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

>>> hw/rtl/stepper_step_dir_generator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stepper_step_dir_generator_unit - step/direction generator for one axis
// Keeps position, target and last step time; turns ticks into step pin
// toggles and moves into step targets, using a serial multiplier and divider.
// ----------------------------------------------------------------------------
//  channel   dir  signals                              contents
//  s_axis    in   tvalid tready tdata[63:0] tuser[2:0] command item
//  m_axis    out  tvalid tready tdata[87:0]            status result item
//  cfg       in   i_cfg_we i_cfg_addr i_cfg_wdata      steps/mm, speed, settle
//
//  One item at a time. Home, enable, disable without divide and clear go
//  straight to the result. Move: serial multiply, round and sign, relative add.
//  Disable: serial divide for the whole-mm remainder.
//  Tick: serial multiply and serial divide for the period, then a second
//  serial divide for the missed count on a step.
//  A result held by m_axis_tready holds the next result; s_axis_tready is
//  high whenever the sequencer is idle. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
module stepper_step_dir_generator_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // s_axis_tdata: now_time[31:0], target_mm_q8[55:32], relative[56], zero
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,
    // s_axis_tuser: cmd[2:0]
    input  wire logic [2:0]  s_axis_tuser,
    // m_axis_tdata: step_level[0], step_toggles[3:1], direction[4],
    //   driver_enabled[5], moving[6], steps_left[38:7],
    //   position_steps[70:39], missed_count[86:71], zero[87]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [87:0]      m_axis_tdata,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [15:0] i_cfg_wdata
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_TMUL  = 4'd1;
    localparam logic [3:0] S_TDIV  = 4'd2;
    localparam logic [3:0] S_TEVAL = 4'd3;
    localparam logic [3:0] S_TMISS = 4'd4;
    localparam logic [3:0] S_MMUL  = 4'd5;
    localparam logic [3:0] S_MRND  = 4'd6;
    localparam logic [3:0] S_MREL  = 4'd7;
    localparam logic [3:0] S_DDIV  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    localparam int PW = stpdir_pkg::MUL_AW + stpdir_pkg::MUL_BW;
    localparam int DW = stpdir_pkg::DIV_W;

    // state
    logic [3:0]  r_state, n_state;
    logic [31:0] r_pos, n_pos;
    logic [31:0] r_tgt, n_tgt;
    logic [31:0] r_last, n_last;
    logic        r_dir, n_dir;
    logic        r_pulse, n_pulse;
    logic        r_en, n_en;
    logic        r_homed, n_homed;
    logic [15:0] r_missed, n_missed;
    logic [15:0] r_spm, r_speed, r_settle;

    // per-item working registers
    logic [31:0] r_now, n_now;
    logic [31:0] r_hold, n_hold;       // now - settle
    logic [31:0] r_elapsed, n_elapsed;
    logic [31:0] r_period, n_period;
    logic [31:0] r_mag, n_mag;
    logic [31:0] r_tmp, n_tmp;
    logic        r_vneg, n_vneg;
    logic        r_rel, n_rel;
    logic [2:0]  r_tog, n_tog;

    logic                 r_out_valid, n_out_valid;
    stpdir_pkg::t_result  r_out, n_out;

    // arithmetic units
    logic                           mul_start, mul_done;
    logic [stpdir_pkg::MUL_AW-1:0]  mul_a;
    logic [PW-1:0]                  mul_prod;
    logic                           div_start, div_done;
    logic [DW-1:0]                  div_dvd, div_dvs, div_quot, div_rem;

    stpdir_mul #(
        .AW (stpdir_pkg::MUL_AW),
        .BW (stpdir_pkg::MUL_BW)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (r_spm),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    stpdir_div #(
        .W (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    logic        w_accept;
    logic [2:0]  w_cmd;
    logic [23:0] w_v;
    logic [23:0] w_vmag;
    logic [31:0] w_pos_mag;
    logic [PW-1:0] w_rnd;
    logic [32:0] w_sum;
    logic [31:0] w_missed_n;
    logic [2:0]  w_extra;
    logic [32:0] w_d_tp, w_d_pt;
    logic        w_want;

    always_comb begin
        w_accept   = s_axis_tvalid && (r_state == S_IDLE);
        w_cmd      = s_axis_tuser;
        w_v        = s_axis_tdata[55:32];
        w_vmag     = w_v[23] ? (~w_v + 24'd1) : w_v;
        w_pos_mag  = r_pos[31] ? (~r_pos + 32'd1) : r_pos;
        w_rnd      = mul_prod + PW'(128);
        w_sum      = {r_tmp[31], r_tmp} + {r_pos[31], r_pos};
        w_missed_n = div_quot - 32'd1;
        w_extra    = w_missed_n[2:0] - 3'd2;
        w_want     = $signed(r_pos) < $signed(r_tgt);
        w_d_tp     = {r_tgt[31], r_tgt} - {r_pos[31], r_pos};
        w_d_pt     = {r_pos[31], r_pos} - {r_tgt[31], r_tgt};
    end

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_tgt       = r_tgt;
        n_last      = r_last;
        n_dir       = r_dir;
        n_pulse     = r_pulse;
        n_en        = r_en;
        n_homed     = r_homed;
        n_missed    = r_missed;
        n_now       = r_now;
        n_hold      = r_hold;
        n_elapsed   = r_elapsed;
        n_period    = r_period;
        n_mag       = r_mag;
        n_tmp       = r_tmp;
        n_vneg      = r_vneg;
        n_rel       = r_rel;
        n_tog       = r_tog;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        mul_start   = 1'b0;
        mul_a       = {8'd0, r_speed};
        div_start   = 1'b0;
        div_dvd     = stpdir_pkg::PERIOD_NUM;
        div_dvs     = mul_prod[DW-1:0];

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_tog     = 3'd0;
                    n_now     = s_axis_tdata[31:0];
                    n_hold    = s_axis_tdata[31:0] - {16'd0, r_settle};
                    n_elapsed = s_axis_tdata[31:0] - r_last;
                    n_rel     = s_axis_tdata[56];
                    n_vneg    = w_v[23];
                    n_state   = S_DONE;
                    case (w_cmd)
                        stpdir_pkg::CMD_TICK: begin
                            if (r_en) begin
                                if (r_pos == r_tgt) begin
                                    n_last = 32'd0;
                                end else begin
                                    mul_start = 1'b1;
                                    n_state   = S_TMUL;
                                end
                            end
                        end
                        stpdir_pkg::CMD_MOVE: begin
                            mul_a     = w_vmag;
                            mul_start = 1'b1;
                            n_state   = S_MMUL;
                        end
                        stpdir_pkg::CMD_HOME: begin
                            n_pos   = 32'd0;
                            n_dir   = 1'b0;
                            n_homed = 1'b1;
                        end
                        stpdir_pkg::CMD_ENABLE: begin
                            n_en = 1'b1;
                        end
                        stpdir_pkg::CMD_DISABLE: begin
                            n_en = 1'b0;
                            if (r_spm == 16'd0) begin
                                n_tgt = r_pos;
                            end else begin
                                div_dvd   = w_pos_mag;
                                div_dvs   = {16'd0, r_spm};
                                div_start = 1'b1;
                                n_state   = S_DDIV;
                            end
                        end
                        stpdir_pkg::CMD_CLEAR: begin
                            n_missed = 16'd0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_TMUL: begin
                if (mul_done) begin
                    // zero speed or zero steps/mm: no step at all
                    if (mul_prod == '0) begin
                        n_state = S_DONE;
                    end else begin
                        div_start = 1'b1;
                        n_state   = S_TDIV;
                    end
                end
            end
            S_TDIV: begin
                if (div_done) begin
                    n_period = (div_quot == '0) ? 32'd1 : div_quot;
                    n_state  = S_TEVAL;
                end
            end
            S_TEVAL: begin
                n_state = S_DONE;
                if (w_want != r_dir) begin
                    n_dir  = w_want;
                    n_last = r_hold + r_period;
                end else if (!r_elapsed[31] && (r_elapsed >= r_period)) begin
                    n_pulse = ~r_pulse;
                    n_tog   = 3'd1;
                    n_last  = r_now;
                    n_pos   = r_dir ? (r_pos + 32'd1) : (r_pos - 32'd1);
                    if (r_last != 32'd0) begin
                        div_dvd   = r_elapsed;
                        div_dvs   = r_period;
                        div_start = 1'b1;
                        n_state   = S_TMISS;
                    end
                end
            end
            S_TMISS: begin
                if (div_done) begin
                    // three to five missed periods earn catch-up toggles
                    if (w_missed_n >= 32'd3 && w_missed_n <= 32'd5) begin
                        n_tog   = 3'd1 + w_extra;
                        n_pulse = r_pulse ^ w_extra[0];
                    end
                    n_missed = r_missed + w_missed_n[15:0];
                    n_state  = S_DONE;
                end
            end
            S_MMUL: begin
                if (mul_done) begin
                    n_mag   = w_rnd[PW-1:8];
                    n_state = S_MRND;
                end
            end
            S_MRND: begin
                if (r_vneg) begin
                    n_tmp = r_mag[31] ? 32'h8000_0000 : (~r_mag + 32'd1);
                end else begin
                    n_tmp = r_mag[31] ? 32'h7FFF_FFFF : r_mag;
                end
                n_state = S_MREL;
            end
            S_MREL: begin
                if (r_rel && r_homed) begin
                    if (w_sum[32] != w_sum[31]) begin
                        n_tgt = w_sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    end else begin
                        n_tgt = w_sum[31:0];
                    end
                end else begin
                    n_tgt = r_tmp;
                end
                n_state = S_DONE;
            end
            S_DDIV: begin
                if (div_done) begin
                    // truncate toward zero to whole mm
                    n_tgt   = r_pos[31] ? (r_pos + div_rem) : (r_pos - div_rem);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid          = 1'b1;
                    n_out.pad            = 1'b0;
                    n_out.missed_count   = r_missed;
                    n_out.position_steps = r_pos;
                    n_out.steps_left     = w_d_tp[32] ? w_d_pt[31:0] : w_d_tp[31:0];
                    n_out.moving         = (r_pos != r_tgt);
                    n_out.driver_enabled = r_en;
                    n_out.direction      = r_dir;
                    n_out.step_toggles   = r_tog;
                    n_out.step_level     = r_pulse;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= 32'd0;
            r_tgt       <= 32'd0;
            r_last      <= 32'd0;
            r_dir       <= 1'b0;
            r_pulse     <= 1'b0;
            r_en        <= 1'b0;
            r_homed     <= 1'b0;
            r_missed    <= 16'd0;
            r_spm       <= stpdir_pkg::SPM_RESET;
            r_speed     <= stpdir_pkg::SPEED_RESET;
            r_settle    <= stpdir_pkg::SETTLE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_tgt       <= n_tgt;
            r_last      <= n_last;
            r_dir       <= n_dir;
            r_pulse     <= n_pulse;
            r_en        <= n_en;
            r_homed     <= n_homed;
            r_missed    <= n_missed;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    stpdir_pkg::REG_SPM:    r_spm    <= i_cfg_wdata;
                    stpdir_pkg::REG_SPEED:  r_speed  <= i_cfg_wdata;
                    stpdir_pkg::REG_SETTLE: r_settle <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_now     <= n_now;
        r_hold    <= n_hold;
        r_elapsed <= n_elapsed;
        r_period  <= n_period;
        r_mag     <= n_mag;
        r_tmp     <= n_tmp;
        r_vneg    <= n_vneg;
        r_rel     <= n_rel;
        r_tog     <= n_tog;
        r_out     <= n_out;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

endmodule
`default_nettype wire

>>> hw/rtl/stpdir_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stpdir_checker - port-level checks for the step/direction generator
// Watches the stream ports and flags inconsistent results or handshakes.
// ----------------------------------------------------------------------------
module stpdir_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [87:0] m_axis_tdata
);
    // a held result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // moving flag agrees with the distance left
    a_moving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[6] == (m_axis_tdata[38:7] != 32'd0)))
        else $error("moving flag disagrees with steps_left");

    // at most one step plus three catch-up toggles per item
    a_toggles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[3:1] <= 3'd4))
        else $error("too many step toggles");

    // one item in flight: input closes right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item accepted while busy");

endmodule

bind stepper_step_dir_generator_unit stpdir_checker u_stpdir_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
